/* hdl/q248_pkg.sv */
// Shared types and constants of the Q24.8 fixed-point arithmetic unit.
`default_nettype none
package q248_pkg;

    localparam int WORD_BITS     = 32;
    localparam int FRACTION_BITS = 8;
    localparam int NUM_BITS      = WORD_BITS + FRACTION_BITS;
    localparam int REM_BITS      = WORD_BITS + 1;
    localparam int PROD_BITS     = 2 * WORD_BITS;

    typedef enum logic [3:0] {
        OP_ADD    = 4'd0,
        OP_SUB    = 4'd1,
        OP_MUL    = 4'd2,
        OP_DIV    = 4'd3,
        OP_LT     = 4'd4,
        OP_LE     = 4'd5,
        OP_GT     = 4'd6,
        OP_GE     = 4'd7,
        OP_EQ     = 4'd8,
        OP_NE     = 4'd9,
        OP_MIN    = 4'd10,
        OP_MAX    = 4'd11,
        OP_INC    = 4'd12,
        OP_TO_INT = 4'd13
    } op_t;

    typedef enum logic [1:0] {
        KIND_DONE = 2'd0,
        KIND_MUL  = 2'd1,
        KIND_DIV  = 2'd2
    } kind_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef struct packed {
        kind_t                 kind;
        logic                  neg;
        logic [WORD_BITS-1:0]  mag_a;
        logic [WORD_BITS-1:0]  mag_b;
        logic [WORD_BITS-1:0]  value;
        logic                  flag;
        logic [1:0]            status;
    } item_t;

endpackage
`default_nettype wire

/* hdl/q248_front.sv */
// Front end: accepts requests, finishes the simple operations, prepares mul/div.
`default_nettype none
module q248_front (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         s_valid,
    output logic                        s_ready,
    input  wire  [3:0]                  s_req_type,
    input  wire  [31:0]                 s_operand_a,
    input  wire  [31:0]                 s_operand_b,
    output logic                        f_valid,
    input  wire                         f_ready,
    output q248_pkg::item_t             f_item
);
    import q248_pkg::*;

    logic                 valid_reg, valid_next;
    item_t                item_reg, item_next;
    logic signed [31:0]   a, b;
    logic signed [32:0]   sum_add, sum_sub, sum_inc;
    logic                 a_lt_b, b_lt_a;

    function automatic logic [31:0] sat33(input logic signed [32:0] s);
        sat33 = (s[32] != s[31]) ? (s[32] ? 32'h8000_0000 : 32'h7fff_ffff) : s[31:0];
    endfunction

    assign a       = s_operand_a;
    assign b       = s_operand_b;
    assign sum_add = {a[31], a} + {b[31], b};
    assign sum_sub = {a[31], a} - {b[31], b};
    assign sum_inc = {a[31], a} + 33'sd1;
    assign a_lt_b  = a < b;
    assign b_lt_a  = b < a;

    assign s_ready = !valid_reg || f_ready;
    assign f_valid = valid_reg;
    assign f_item  = item_reg;

    always_comb begin
        item_next        = '0;
        item_next.kind   = KIND_DONE;
        item_next.neg    = a[31] ^ b[31];
        item_next.mag_a  = a[31] ? 32'(-a) : a;
        item_next.mag_b  = b[31] ? 32'(-b) : b;
        unique case (s_req_type)
            OP_ADD: begin
                item_next.value  = sat33(sum_add);
                item_next.status = (sum_add[32] != sum_add[31]) ? ST_SAT : ST_OK;
            end
            OP_SUB: begin
                item_next.value  = sat33(sum_sub);
                item_next.status = (sum_sub[32] != sum_sub[31]) ? ST_SAT : ST_OK;
            end
            OP_INC: begin
                item_next.value  = sat33(sum_inc);
                item_next.status = (sum_inc[32] != sum_inc[31]) ? ST_SAT : ST_OK;
            end
            OP_MUL: item_next.kind = KIND_MUL;
            OP_DIV: begin
                if (b == 32'sd0) begin
                    item_next.status = ST_DIV0;
                end else begin
                    item_next.kind = KIND_DIV;
                end
            end
            OP_LT:  item_next.flag = a_lt_b;
            OP_LE:  item_next.flag = !b_lt_a;
            OP_GT:  item_next.flag = b_lt_a;
            OP_GE:  item_next.flag = !a_lt_b;
            OP_EQ:  item_next.flag = (a == b);
            OP_NE:  item_next.flag = (a != b);
            OP_MIN: item_next.value = b_lt_a ? b : a;
            OP_MAX: item_next.value = b_lt_a ? a : b;
            OP_TO_INT: item_next.value = a >>> FRACTION_BITS;
            default: ;
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= item_next;
        end
    end

endmodule
`default_nettype wire

/* hdl/q248_queue.sv */
// Two-entry queue between the front end and the execution pipeline.
`default_nettype none
module q248_queue (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 wr_valid,
    output logic                wr_ready,
    input  q248_pkg::item_t     wr_item,
    output logic                rd_valid,
    input  wire                 rd_ready,
    output q248_pkg::item_t     rd_item
);
    import q248_pkg::*;

    item_t        mem_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;
    logic         push, pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_item  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule
`default_nettype wire

/* hdl/q248_back.sv */
// Execution pipeline: registered multiply, one quotient bit per stage, round and clamp.
`default_nettype none
module q248_back (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 q_valid,
    output logic                q_ready,
    input  q248_pkg::item_t     q_item,
    output logic                m_valid,
    input  wire                 m_ready,
    output logic [31:0]         m_result_value,
    output logic                m_compare_flag,
    output logic [1:0]          m_status
);
    import q248_pkg::*;

    logic                    adv;
    logic                    vld_reg  [0:NUM_BITS];
    item_t                   item_reg [0:NUM_BITS];
    logic [PROD_BITS-1:0]    prod_reg;
    logic [REM_BITS-1:0]     rem_reg  [1:NUM_BITS];
    logic [NUM_BITS-1:0]     quo_reg  [1:NUM_BITS];

    logic                    out_valid_reg;
    logic [WORD_BITS-1:0]    out_value_reg, out_value_next;
    logic                    out_flag_reg;
    logic [1:0]              out_status_reg, out_status_next;

    // product rounding, resolved in the first divide stage
    logic [PROD_BITS:0]      prod_rnd;
    logic [PROD_BITS-FRACTION_BITS:0] prod_mag;
    item_t                   mul_item;

    // final quotient rounding
    item_t                   last_item;
    logic [REM_BITS:0]       rem_x2;
    logic [NUM_BITS:0]       quo_rnd;
    logic [NUM_BITS:0]       limit;

    assign adv     = !out_valid_reg || m_ready;
    assign q_ready = adv;

    assign prod_rnd = {1'b0, prod_reg} + (PROD_BITS+1)'(1 << (FRACTION_BITS - 1));
    assign prod_mag = prod_rnd[PROD_BITS:FRACTION_BITS];

    always_comb begin
        mul_item = item_reg[0];
        if (item_reg[0].kind == KIND_MUL) begin
            mul_item.kind = KIND_DONE;
            if (prod_mag > (PROD_BITS-FRACTION_BITS+1)'({item_reg[0].neg,
                                                       {(WORD_BITS-1){!item_reg[0].neg}}})) begin
                mul_item.status = ST_SAT;
                mul_item.value  = item_reg[0].neg ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                                  : {1'b0, {(WORD_BITS-1){1'b1}}};
            end else begin
                mul_item.value = item_reg[0].neg ? WORD_BITS'(-prod_mag)
                                                 : prod_mag[WORD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            item_reg[0] <= q_item;
            prod_reg    <= q_item.mag_a * q_item.mag_b;
        end
    end

    genvar s;
    generate
        for (s = 1; s <= NUM_BITS; s++) begin : g_stage
            logic [REM_BITS-1:0] rem_in;
            logic [NUM_BITS-1:0] quo_in;
            logic [NUM_BITS-1:0] numer;
            logic [REM_BITS:0]   trial;
            logic                take;
            item_t               item_in;

            if (s == 1) begin : g_first
                assign rem_in  = '0;
                assign quo_in  = '0;
                assign item_in = mul_item;
            end else begin : g_rest
                assign rem_in  = rem_reg[s-1];
                assign quo_in  = quo_reg[s-1];
                assign item_in = item_reg[s-1];
            end

            assign numer = {item_in.mag_a, {FRACTION_BITS{1'b0}}};
            assign trial = {rem_in, numer[NUM_BITS-s]};
            assign take  = trial >= {2'b00, item_in.mag_b};

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[s] <= 1'b0;
                end else if (adv) begin
                    vld_reg[s] <= vld_reg[s-1];
                end
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    item_reg[s] <= item_in;
                    rem_reg[s]  <= take ? REM_BITS'(trial - {2'b00, item_in.mag_b})
                                        : trial[REM_BITS-1:0];
                    quo_reg[s]  <= {quo_in[NUM_BITS-2:0], take};
                end
            end
        end
    endgenerate

    assign last_item = item_reg[NUM_BITS];
    assign rem_x2    = {rem_reg[NUM_BITS], 1'b0};
    assign quo_rnd   = {1'b0, quo_reg[NUM_BITS]} +
                       (NUM_BITS+1)'(rem_x2 >= {2'b00, last_item.mag_b});
    assign limit     = (NUM_BITS+1)'({last_item.neg, {(WORD_BITS-1){!last_item.neg}}});

    always_comb begin
        out_value_next  = last_item.value;
        out_status_next = last_item.status;
        if (last_item.kind == KIND_DIV) begin
            if (quo_rnd > limit) begin
                out_status_next = ST_SAT;
                out_value_next  = last_item.neg ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                                : {1'b0, {(WORD_BITS-1){1'b1}}};
            end else begin
                out_value_next = last_item.neg ? WORD_BITS'(-quo_rnd)
                                               : quo_rnd[WORD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= vld_reg[NUM_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_value_reg  <= out_value_next;
            out_flag_reg   <= last_item.flag;
            out_status_reg <= out_status_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_result_value = out_value_reg;
    assign m_compare_flag = out_flag_reg;
    assign m_status       = out_status_reg;

endmodule
`default_nettype wire

/* hdl/q24_8_fixed_point_alu_top.sv */
// Top level of the Q24.8 fixed-point arithmetic unit.
// Accepts one operation per cycle while the output is not stalled, and returns
// one result per operation, in order. Every operation passes through one front
// register, one queue slot, the registered 32x32 multiply, 40 restoring-divide
// stages (one quotient bit each) and the output register; simple operations ride
// the same pipeline. Products and quotients are exact, rounded half away from zero
// and clamped to the 32-bit range with status 2; divide by zero gives 0, status 1.
`default_nettype none
module q24_8_fixed_point_alu_top (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_valid,
    output logic         s_ready,
    input  wire  [3:0]   s_req_type,
    input  wire  [31:0]  s_operand_a,
    input  wire  [31:0]  s_operand_b,
    output logic         m_valid,
    input  wire          m_ready,
    output logic [31:0]  m_result_value,
    output logic         m_compare_flag,
    output logic [1:0]   m_status
);
    import q248_pkg::*;

    logic   f_valid, f_ready;
    item_t  f_item;
    logic   q_valid, q_ready;
    item_t  q_item;

    q248_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_operand_a (s_operand_a),
        .s_operand_b (s_operand_b),
        .f_valid     (f_valid),
        .f_ready     (f_ready),
        .f_item      (f_item)
    );

    q248_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_item  (f_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item)
    );

    q248_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_item         (q_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_compare_flag (m_compare_flag),
        .m_status       (m_status)
    );

endmodule
`default_nettype wire

/* hdl/q248_checker.sv */
// Port-level checks of the arithmetic unit, bound to the top level.
`default_nettype none
module q248_checker (
    input wire         aclk,
    input wire         aresetn,
    input wire         m_valid,
    input wire         m_ready,
    input wire [31:0]  m_result_value,
    input wire         m_compare_flag,
    input wire [1:0]   m_status
);
    import q248_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_value) && $stable(m_status))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_compare_flag |-> m_result_value == 32'd0 && m_status == ST_OK)
        else $error("comparison result carries a value");

    a_div0: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_DIV0 |-> m_result_value == 32'd0 && !m_compare_flag)
        else $error("divide by zero carries a value");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status != 2'd3)
        else $error("status code out of range");

endmodule

bind q24_8_fixed_point_alu_top q248_checker u_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_result_value (m_result_value),
    .m_compare_flag (m_compare_flag),
    .m_status       (m_status)
);
`default_nettype wire
